// ===== rtl/core/cpo_pkg.sv =====
// Shared constants and elaboration-time helpers for the capsule pair overlap test.
// No dependencies.
package cpo_pkg;

    // Squared-height threshold is 1e-6 in real units
    localparam longint unsigned DEGEN_DEN = 64'd1000000;

    // Largest raw height magnitude whose square is at or below the threshold
    function automatic longint unsigned degen_mag(input int frac_bits);
        longint unsigned lim;
        longint unsigned m;
        lim = (64'd1 << (2 * frac_bits)) / DEGEN_DEN;
        m = 64'd0;
        while ((m + 64'd1) * (m + 64'd1) <= lim)
            m = m + 64'd1;
        return m;
    endfunction

endpackage

// ===== rtl/core/cpo_pair_if.sv =====
// Request and result channel interfaces for the capsule pair overlap test.
// No dependencies.
interface cpo_pair_if #(parameter int COORD_BITS = 32);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS-1:0]   first_base_x;
    logic signed [COORD_BITS-1:0]   first_base_y;
    logic signed [COORD_BITS-1:0]   first_base_z;
    logic signed [COORD_BITS-1:0]   first_height;
    logic        [COORD_BITS-2:0]   first_radius;
    logic signed [COORD_BITS-1:0]   second_base_x;
    logic signed [COORD_BITS-1:0]   second_base_y;
    logic signed [COORD_BITS-1:0]   second_base_z;
    logic signed [COORD_BITS-1:0]   second_height;
    logic        [COORD_BITS-2:0]   second_radius;

    modport source (output valid, first_base_x, first_base_y, first_base_z, first_height,
                    first_radius, second_base_x, second_base_y, second_base_z,
                    second_height, second_radius, input ready);
    modport sink   (input valid, first_base_x, first_base_y, first_base_z, first_height,
                    first_radius, second_base_x, second_base_y, second_base_z,
                    second_height, second_radius, output ready);
endinterface

interface cpo_result_if #(parameter int COORD_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic                   overlapping;
    logic [COORD_BITS:0]    axis_distance;

    modport source (output valid, overlapping, axis_distance, input ready);
    modport sink   (input valid, overlapping, axis_distance, output ready);
endinterface

// ===== rtl/core/capsule_pair_overlap_test.sv =====
// Top level of the capsule pair overlap test: segment gap, squares and a bit-serial
// pipelined square root. Depends on cpo_pkg and the cpo_pair_if / cpo_result_if interfaces.
//
// Takes one capsule pair per cycle while the output is free and returns one result per
// pair, in order. The pipe is five stages of difference, interval gap, squaring and
// summing, one stage per root bit of the square root (COORD_BITS + 2 stages), and the
// output register. The whole pipeline holds while a result waits at the output and is
// not taken.
module capsule_pair_overlap_test #(
    parameter int FRACTION_BITS = 16,
    parameter int COORD_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    cpo_pair_if.sink    pair,
    cpo_result_if.source result
);

    localparam int C      = COORD_BITS;
    localparam int D      = C + 1;        // difference / magnitude width
    localparam int SQ_W   = 2 * D;        // one square
    localparam int RES_W  = C + 2;        // square root width
    localparam int RAD_W  = 2 * RES_W;    // radicand width
    localparam int REM_W  = RES_W + 2;    // partial remainder width
    localparam logic [C-1:0] DEGEN_MAG =
        C'(cpo_pkg::degen_mag(FRACTION_BITS));

    logic adv;

    // Advance the whole pipe unless a result is stuck at the output
    assign adv        = !result.valid || result.ready;
    assign pair.ready = adv;

    // ---------------- stage 1: base differences, degenerate heights
    logic                 v1_reg;
    logic signed [D-1:0]  dx1_reg, dz1_reg;
    logic signed [C-1:0]  ay1_reg, by1_reg, ah1_reg, bh1_reg;
    logic        [C-1:0]  rsum1_reg;
    logic        [C-1:0]  ah_mag, bh_mag;

    assign ah_mag = pair.first_height[C-1]  ? C'(-pair.first_height)  : C'(pair.first_height);
    assign bh_mag = pair.second_height[C-1] ? C'(-pair.second_height) : C'(pair.second_height);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg   <= D'(pair.first_base_x) - D'(pair.second_base_x);
            dz1_reg   <= D'(pair.first_base_z) - D'(pair.second_base_z);
            ay1_reg   <= pair.first_base_y;
            by1_reg   <= pair.second_base_y;
            ah1_reg   <= (ah_mag <= DEGEN_MAG) ? '0 : pair.first_height;
            bh1_reg   <= (bh_mag <= DEGEN_MAG) ? '0 : pair.second_height;
            rsum1_reg <= C'(pair.first_radius) + C'(pair.second_radius);
        end
    end

    // ---------------- stage 2: axis ends, magnitudes of dx and dz
    logic signed [D-1:0]  ay2_reg, by2_reg, aend2_reg, bend2_reg;
    logic        [D-1:0]  dx2_reg, dz2_reg;
    logic        [C-1:0]  rsum2_reg;
    logic                 v2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ay2_reg   <= D'(ay1_reg);
            by2_reg   <= D'(by1_reg);
            aend2_reg <= D'(ay1_reg) + D'(ah1_reg);
            bend2_reg <= D'(by1_reg) + D'(bh1_reg);
            dx2_reg   <= dx1_reg[D-1] ? D'(-dx1_reg) : D'(dx1_reg);
            dz2_reg   <= dz1_reg[D-1] ? D'(-dz1_reg) : D'(dz1_reg);
            rsum2_reg <= rsum1_reg;
        end
    end

    // ---------------- stage 3: gap between the y intervals
    logic signed [D-1:0]  alo, ahi, blo, bhi;
    logic        [D-1:0]  gap;
    logic        [D-1:0]  dx3_reg, dz3_reg, dy3_reg;
    logic        [C-1:0]  rsum3_reg;
    logic                 v3_reg;

    always_comb
    begin
        alo = (ay2_reg < aend2_reg) ? ay2_reg : aend2_reg;
        ahi = (ay2_reg < aend2_reg) ? aend2_reg : ay2_reg;
        blo = (by2_reg < bend2_reg) ? by2_reg : bend2_reg;
        bhi = (by2_reg < bend2_reg) ? bend2_reg : by2_reg;
        if (blo > ahi)
            gap = D'(blo - ahi);
        else if (alo > bhi)
            gap = D'(alo - bhi);
        else
            gap = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx3_reg   <= dx2_reg;
            dz3_reg   <= dz2_reg;
            dy3_reg   <= gap;
            rsum3_reg <= rsum2_reg;
        end
    end

    // ---------------- stage 4: squares
    logic [SQ_W-1:0] sx4_reg, sy4_reg, sz4_reg;
    logic [C-1:0]    rsum4_reg;
    logic            v4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx4_reg   <= SQ_W'(dx3_reg) * SQ_W'(dx3_reg);
            sy4_reg   <= SQ_W'(dy3_reg) * SQ_W'(dy3_reg);
            sz4_reg   <= SQ_W'(dz3_reg) * SQ_W'(dz3_reg);
            rsum4_reg <= rsum3_reg;
        end
    end

    // ---------------- stage 5: sum of squares feeds the root pipe
    logic [RAD_W-1:0] rad_reg  [0:RES_W];
    logic [REM_W-1:0] rem_reg  [0:RES_W];
    logic [RES_W-1:0] root_reg [0:RES_W];
    logic [C-1:0]     rs_reg   [0:RES_W];
    logic             vs_reg   [0:RES_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg[0]  <= RAD_W'(sx4_reg) + RAD_W'(sy4_reg) + RAD_W'(sz4_reg);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rs_reg[0]   <= rsum4_reg;
        end
    end

    // ---------------- root stages: one result bit each
    genvar k;
    generate
        for (k = 0; k < RES_W; k++)
        begin : g_root
            logic [REM_W-1:0] cur;
            logic [REM_W-1:0] trial;

            assign cur   = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
            assign trial = {root_reg[k], 2'b01};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg[k+1] <= {rad_reg[k][RAD_W-3:0], 2'b00};
                    rs_reg[k+1]  <= rs_reg[k];
                    if (cur >= trial)
                    begin
                        rem_reg[k+1]  <= cur - trial;
                        root_reg[k+1] <= {root_reg[k][RES_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k+1]  <= cur;
                        root_reg[k+1] <= {root_reg[k][RES_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vs_reg[k+1] <= 1'b0;
                else if (adv)
                    vs_reg[k+1] <= vs_reg[k];
            end
        end
    endgenerate

    // ---------------- output register: compare and saturate
    logic             out_valid_reg;
    logic             overlap_reg;
    logic [C:0]       dist_reg;
    logic [RES_W-1:0] root_fin;

    assign root_fin = root_reg[RES_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            overlap_reg <= root_fin < RES_W'(rs_reg[RES_W]);
            dist_reg    <= root_fin[RES_W-1] ? '1 : root_fin[C:0];
        end
    end

    // Move valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            vs_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= pair.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            vs_reg[0]     <= v4_reg;
            out_valid_reg <= vs_reg[RES_W];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.overlapping   = overlap_reg;
    assign result.axis_distance = dist_reg;

endmodule

// ===== rtl/core/cpo_checker.sv =====
// Port-level checks for capsule_pair_overlap_test, attached by bind.
// Depends on capsule_pair_overlap_test and its channel interfaces.
module cpo_checker #(
    parameter int COORD_BITS = 32
) (
    input logic                clk,
    input logic                rst_n,
    input logic                pair_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic                overlapping,
    input logic [COORD_BITS:0] axis_distance
);

    // Stall the request side whenever a result is held back
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !pair_ready)
        else $error("request taken while result stalled");

    // Take requests whenever the output is free
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid || result_ready) |-> pair_ready)
        else $error("request refused with free output");

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(overlapping) && $stable(axis_distance)))
        else $error("stalled result changed");

    // No result appears out of an idle pipe right after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid out of reset");

endmodule

bind capsule_pair_overlap_test cpo_checker #(.COORD_BITS(COORD_BITS)) u_cpo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair_ready    (pair.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .overlapping   (result.overlapping),
    .axis_distance (result.axis_distance)
);
